FILE: hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg : websocket deframer shared types
// Opcodes, result kinds and the result record passed from parser to output.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  // frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_CTRL    = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_BAD_OP  = 2'd3;

  // configuration register indexes
  localparam logic REG_DELIVER_BINARY = 1'b0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  opcode;
    logic        last;
    logic [15:0] close_status;
  } wsd_result_t;

endpackage : wsd_pkg

`default_nettype wire

FILE: hdl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser : websocket frame header decode and payload unmask
// Holds the frame and message state; gives at most one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               byte_valid,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               deliver_binary,
  output wsd_pkg::wsd_result_t    res,
  output logic                    res_valid
);

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX     = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX_SHR = LEN_MAX >> 8;

  phase_t                  phase_r, phase_nxt;
  logic [3:0]              hdr_cnt_r, hdr_cnt_nxt;
  logic                    fin_r, fin_nxt;
  logic                    masked_r, masked_nxt;
  logic [3:0]              frame_op_r, frame_op_nxt;
  // length on entry to payload, then bytes still to come
  logic [LENGTH_BITS-1:0]  len_r, len_nxt;
  logic [31:0]             key_r, key_nxt;
  logic [3:0]              msg_type_r, msg_type_nxt;
  logic                    msg_active_r, msg_active_nxt;
  logic [15:0]             status_r, status_nxt;
  logic                    stopped_r, stopped_nxt;
  logic [1:0]              idx_r, idx_nxt;      // payload index mod 4
  logic                    wrap_r, wrap_nxt;    // payload index has passed 3

  logic [3:0]              eff_op;
  logic                    is_ctrl;
  logic [3:0]              hdr_cnt_dec;
  logic [LENGTH_BITS-1:0]  ext_len;
  logic [LENGTH_BITS-1:0]  hdr_len;
  logic                    hdr_done;
  logic [7:0]              key_byte;
  logic [7:0]              plain;
  logic                    at_end;
  logic                    first_byte;
  logic                    second_byte;
  logic                    op_ok;

  always_comb begin
    if (frame_op_r == wsd_pkg::OP_CONT) begin
      eff_op = msg_active_r ? msg_type_r : wsd_pkg::OP_CONT;
    end else begin
      eff_op = frame_op_r;
    end
  end

  assign is_ctrl     = frame_op_r[3];
  assign hdr_cnt_dec = hdr_cnt_r - 4'd1;
  assign ext_len     = (len_r > LEN_MAX_SHR) ? LEN_MAX
                                             : {len_r[LENGTH_BITS-9:0], rx_byte};
  assign at_end      = (len_r == LENGTH_BITS'(1));
  assign first_byte  = (idx_r == 2'd0) && !wrap_r;
  assign second_byte = (idx_r == 2'd1) && !wrap_r;

  always_comb begin
    unique case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign plain = masked_r ? (rx_byte ^ key_byte) : rx_byte;

  assign op_ok = (rx_byte[3:0] == wsd_pkg::OP_CONT)  || (rx_byte[3:0] == wsd_pkg::OP_TEXT) ||
                 (rx_byte[3:0] == wsd_pkg::OP_BIN)   || (rx_byte[3:0] == wsd_pkg::OP_CLOSE) ||
                 (rx_byte[3:0] == wsd_pkg::OP_PING)  || (rx_byte[3:0] == wsd_pkg::OP_PONG);

  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    fin_nxt        = fin_r;
    masked_nxt     = masked_r;
    frame_op_nxt   = frame_op_r;
    len_nxt        = len_r;
    key_nxt        = key_r;
    msg_type_nxt   = msg_type_r;
    msg_active_nxt = msg_active_r;
    status_nxt     = status_r;
    stopped_nxt    = stopped_r;
    idx_nxt        = idx_r;
    wrap_nxt       = wrap_r;
    res_valid      = 1'b0;
    res            = '0;
    hdr_done       = 1'b0;
    hdr_len        = len_r;

    if (byte_valid && !stopped_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt      = rx_byte[7];
          frame_op_nxt = rx_byte[3:0];
          status_nxt   = '0;
          if (!op_ok) begin
            stopped_nxt = 1'b1;
            res_valid   = 1'b1;
            res.kind    = wsd_pkg::KIND_BAD_OP;
            res.opcode  = rx_byte[3:0];
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          key_nxt    = '0;
          if (rx_byte[6:1] == 6'h3f) begin
            // 126 or 127: extended length follows
            hdr_cnt_nxt = rx_byte[0] ? 4'd8 : 4'd2;
            len_nxt     = '0;
            phase_nxt   = PH_EXTLEN;
          end else begin
            len_nxt = LENGTH_BITS'(rx_byte[6:0]);
            if (rx_byte[7]) begin
              hdr_cnt_nxt = 4'd4;
              phase_nxt   = PH_MASK;
            end else begin
              hdr_done = 1'b1;
              hdr_len  = LENGTH_BITS'(rx_byte[6:0]);
            end
          end
        end
        PH_EXTLEN: begin
          len_nxt     = ext_len;
          hdr_cnt_nxt = hdr_cnt_dec;
          if (hdr_cnt_dec == 4'd0) begin
            if (masked_r) begin
              hdr_cnt_nxt = 4'd4;
              phase_nxt   = PH_MASK;
            end else begin
              hdr_done = 1'b1;
              hdr_len  = ext_len;
            end
          end
        end
        PH_MASK: begin
          key_nxt     = {key_r[23:0], rx_byte};
          hdr_cnt_nxt = hdr_cnt_dec;
          if (hdr_cnt_dec == 4'd0) begin
            hdr_done = 1'b1;
            hdr_len  = len_r;
          end
        end
        PH_PAYLOAD: begin
          if (frame_op_r == wsd_pkg::OP_CLOSE) begin
            if (first_byte) begin
              status_nxt = {plain, 8'h00};
            end else if (second_byte) begin
              status_nxt = {status_r[15:8], plain};
            end
          end
          if ((eff_op == wsd_pkg::OP_TEXT) ||
              ((eff_op == wsd_pkg::OP_BIN) && deliver_binary)) begin
            res_valid     = 1'b1;
            res.kind      = wsd_pkg::KIND_DATA;
            res.data_byte = plain;
            res.opcode    = eff_op;
            res.last      = at_end && fin_r;
          end else if ((eff_op == wsd_pkg::OP_CLOSE) || (eff_op == wsd_pkg::OP_PING)) begin
            res_valid     = 1'b1;
            res.kind      = wsd_pkg::KIND_CTRL;
            res.data_byte = plain;
            res.opcode    = eff_op;
            res.last      = at_end;
            if ((eff_op == wsd_pkg::OP_CLOSE) && !first_byte) begin
              res.close_status = status_nxt;
            end
          end
          if (!at_end) begin
            len_nxt = len_r - LENGTH_BITS'(1);
            idx_nxt = idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              wrap_nxt = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      // header complete: either an empty-frame event or on to the payload
      if (hdr_done) begin
        if (hdr_len == '0) begin
          res_valid  = 1'b1;
          res.kind   = wsd_pkg::KIND_EMPTY;
          res.opcode = eff_op;
          res.last   = is_ctrl || ((eff_op != wsd_pkg::OP_CONT) && fin_r);
        end else begin
          phase_nxt = PH_PAYLOAD;
          idx_nxt   = 2'd0;
          wrap_nxt  = 1'b0;
        end
      end

      // frame finished: settle the message state
      if ((hdr_done && (hdr_len == '0)) || ((phase_r == PH_PAYLOAD) && at_end)) begin
        if (!is_ctrl) begin
          if (frame_op_r != wsd_pkg::OP_CONT) begin
            msg_type_nxt   = frame_op_r;
            msg_active_nxt = !fin_r;
          end else if (msg_active_r && fin_r) begin
            msg_active_nxt = 1'b0;
          end
        end
        phase_nxt   = PH_HDR0;
        idx_nxt     = 2'd0;
        wrap_nxt    = 1'b0;
        hdr_cnt_nxt = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      hdr_cnt_r    <= '0;
      fin_r        <= 1'b0;
      masked_r     <= 1'b0;
      frame_op_r   <= '0;
      len_r        <= '0;
      key_r        <= '0;
      msg_type_r   <= '0;
      msg_active_r <= 1'b0;
      status_r     <= '0;
      stopped_r    <= 1'b0;
      idx_r        <= '0;
      wrap_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      fin_r        <= fin_nxt;
      masked_r     <= masked_nxt;
      frame_op_r   <= frame_op_nxt;
      len_r        <= len_nxt;
      key_r        <= key_nxt;
      msg_type_r   <= msg_type_nxt;
      msg_active_r <= msg_active_nxt;
      status_r     <= status_nxt;
      stopped_r    <= stopped_nxt;
      idx_r        <= idx_nxt;
      wrap_r       <= wrap_nxt;
    end
  end

endmodule : wsd_parser

`default_nettype wire

FILE: hdl/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core : websocket receive deframer
// Parses frame headers, unmasks payload, reassembles message bytes.
// ----------------------------------------------------------------------------
//  channel  | ports          | beat contents
//  ---------+----------------+------------------------------------------------
//  in       | in_t*          | one raw stream byte
//  out      | out_t*         | data/control byte, empty-frame event or error
//  cfg      | cfg_p*         | deliver_binary at byte address 0
//
// One byte is taken per cycle; its result, if any, is in the output register
// on the next cycle. The output register is the only buffer: input stalls
// only while a result is held and out_tready is low. Header, length and mask
// state is updated as each byte is taken. Synchronous active-low reset; no
// initialisation pass. A bad opcode stops the parser until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_core #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] rx_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,     // [7:0] data_byte, [11:8] opcode,
                                          // [27:12] close_status, [31:28] zero
  output logic [1:0]       out_tuser,     // [1:0] kind
  output logic             out_tlast,     // last
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic                 deliver_binary_r;
  logic                 in_accept;
  logic                 res_valid;
  wsd_pkg::wsd_result_t res;
  logic                 out_valid_r;
  wsd_pkg::wsd_result_t out_r;

  // configuration port
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_binary_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[2] == wsd_pkg::REG_DELIVER_BINARY)) begin
      deliver_binary_r <= cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == wsd_pkg::REG_DELIVER_BINARY) begin
      cfg_prdata[0] = deliver_binary_r;
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_valid     (in_accept),
    .rx_byte        (in_tdata),
    .deliver_binary (deliver_binary_r),
    .res            (res),
    .res_valid      (res_valid)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_r.close_status, out_r.opcode, out_r.data_byte};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule : websocket_frame_deframer_core

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb : websocket deframer testbench
// Streams raw frame bytes into the deframer and checks every result beat
// against a cycle-free model of the parser kept in a small scoreboard. A short
// directed list of frames comes first, then random frames with noise, over
// several settings of deliver_binary, ending with a bad opcode.
// ----------------------------------------------------------------------------
module tb;

  localparam int LENGTH_BITS = 64;
  localparam logic [63:0] LEN_MAX = (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 1);
  // longest quiet stretch in a good run is the receiver hold-off
  localparam int STALL_LIMIT = 3000;

  typedef enum logic [2:0] {AWAIT_HDR0, AWAIT_HDR1, EXT_LEN, MASK_KEY, PAYLOAD} parse_phase_t;
  typedef enum {FORM_7BIT, FORM_16BIT, FORM_64BIT} len_form_t;

  class frame_scoreboard;
    wsd_pkg::wsd_result_t expected_q[$];
    int                   errors;
    bit                   deliver_binary;
    parse_phase_t         phase;
    bit [3:0]             hdr_left;
    bit                   fin;
    bit                   masked;
    bit                   halted;
    bit                   msg_active;
    bit [3:0]             frame_op;
    bit [3:0]             msg_type;
    bit [63:0]            pay_len;
    bit [63:0]            pay_idx;
    bit [31:0]            key;
    bit [15:0]            status;

    function new();
      phase  = AWAIT_HDR0;
      errors = 0;
    endfunction

    static function bit known_opcode(logic [3:0] op);
      case (op)
        wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN,
        wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void queue_result(logic [1:0] kind, logic [7:0] data, logic [3:0] op,
                               logic last, logic [15:0] st);
      wsd_pkg::wsd_result_t r;
      r.kind         = kind;
      r.data_byte    = data;
      r.opcode       = op;
      r.last         = last;
      r.close_status = st;
      expected_q = {expected_q, r};
    endfunction

    // continuations take the type of the open message, orphans report 0
    function logic [3:0] message_opcode();
      if (frame_op == wsd_pkg::OP_CONT) return msg_active ? msg_type : wsd_pkg::OP_CONT;
      return frame_op;
    endfunction

    function void close_frame();
      if (frame_op < wsd_pkg::OP_CLOSE) begin
        if (frame_op != wsd_pkg::OP_CONT) begin
          msg_type   = frame_op;
          msg_active = !fin;
        end else if (msg_active && fin) begin
          msg_active = 1'b0;
        end
      end
      phase    = AWAIT_HDR0;
      pay_idx  = '0;
      hdr_left = '0;
    endfunction

    function void header_done();
      logic [3:0] eff;
      if (pay_len == 0) begin
        eff = message_opcode();
        queue_result(wsd_pkg::KIND_EMPTY, 8'h00, eff,
                     (frame_op >= wsd_pkg::OP_CLOSE) || (eff != wsd_pkg::OP_CONT && fin),
                     16'h0000);
        close_frame();
      end else begin
        phase   = PAYLOAD;
        pay_idx = '0;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [3:0] eff;
      logic [7:0] d;
      bit         at_end;
      if (halted) return;
      case (phase)
        AWAIT_HDR0: begin
          fin      = b[7];
          frame_op = b[3:0];
          status   = '0;
          if (!known_opcode(b[3:0])) begin
            halted = 1'b1;
            queue_result(wsd_pkg::KIND_BAD_OP, 8'h00, b[3:0], 1'b0, 16'h0000);
          end else begin
            phase = AWAIT_HDR1;
          end
        end
        AWAIT_HDR1: begin
          masked  = b[7];
          key     = '0;
          pay_len = '0;
          if (b[6:0] == 7'd127 || b[6:0] == 7'd126) begin
            hdr_left = (b[6:0] == 7'd127) ? 4'd8 : 4'd2;
            phase    = EXT_LEN;
          end else begin
            pay_len = 64'(b[6:0]);
            if (masked) begin
              hdr_left = 4'd4;
              phase    = MASK_KEY;
            end else begin
              header_done();
            end
          end
        end
        EXT_LEN: begin
          if (pay_len > (LEN_MAX >> 8)) pay_len = LEN_MAX;
          else pay_len = {pay_len[55:0], b};
          hdr_left--;
          if (hdr_left == 0) begin
            if (masked) begin
              hdr_left = 4'd4;
              phase    = MASK_KEY;
            end else begin
              header_done();
            end
          end
        end
        MASK_KEY: begin
          key = {key[23:0], b};
          hdr_left--;
          if (hdr_left == 0) header_done();
        end
        PAYLOAD: begin
          eff    = message_opcode();
          at_end = (pay_idx + 1 == pay_len);
          d      = b;
          if (masked) d ^= key[(3 - int'(pay_idx[1:0])) * 8 +: 8];
          if (frame_op == wsd_pkg::OP_CLOSE) begin
            if (pay_idx == 0) status = {d, 8'h00};
            else if (pay_idx == 1) status[7:0] = d;
          end
          if (eff == wsd_pkg::OP_TEXT || (eff == wsd_pkg::OP_BIN && deliver_binary))
            queue_result(wsd_pkg::KIND_DATA, d, eff, at_end && fin, 16'h0000);
          else if (eff == wsd_pkg::OP_CLOSE || eff == wsd_pkg::OP_PING)
            queue_result(wsd_pkg::KIND_CTRL, d, eff, at_end,
                         (eff == wsd_pkg::OP_CLOSE && pay_idx >= 1) ? status : 16'h0000);
          if (at_end) close_frame();
          else pay_idx++;
        end
        default: phase = AWAIT_HDR0;
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [31:0] tdata, logic last);
      wsd_pkg::wsd_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d tdata %h", kind, tdata);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 16'(want.kind), 16'(kind));
      compare_field("data_byte", 16'(want.data_byte), 16'(tdata[7:0]));
      compare_field("opcode", 16'(want.opcode), 16'(tdata[11:8]));
      compare_field("close_status", want.close_status, tdata[27:12]);
      compare_field("tdata_pad", 16'h0000, 16'(tdata[31:28]));
      compare_field("last", 16'(want.last), 16'(last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_scoreboard sb;
  frame_scoreboard tx_view;   // sender's own copy, tracks where the parser stands
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int              rx_hold_req;
  int              stall_cycles;
  int unsigned     bytes_sent;

  websocket_frame_deframer_core #(.LENGTH_BITS(LENGTH_BITS)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_beat(out_tuser, out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    tx_view.note_byte(b);
    tx_view.expected_q.delete();
    bytes_sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [3:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return wsd_pkg::OP_TEXT;
    if (r < 45) return wsd_pkg::OP_BIN;
    if (r < 72) return wsd_pkg::OP_CONT;
    if (r < 81) return wsd_pkg::OP_CLOSE;
    if (r < 91) return wsd_pkg::OP_PING;
    return wsd_pkg::OP_PONG;
  endfunction

  // a stray bad opcode would halt the parser for good, and a wide length
  // would swallow the rest of the run
  task automatic send_noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (tx_view.phase == AWAIT_HDR0 && !frame_scoreboard::known_opcode(b[3:0]))
      b[3:0] = pick_opcode();
    else if (tx_view.phase == EXT_LEN && tx_view.hdr_left >= 2)
      b = 8'h00;
    send_byte(b);
  endtask

  task automatic finish_open_frame();
    while (tx_view.phase != AWAIT_HDR0) send_noise_byte();
  endtask

  // cut drops that many payload bytes from the end, leaving a broken frame
  task automatic send_frame(input bit fin, input logic [3:0] op, input int unsigned len,
                            input bit masked, input len_form_t form,
                            input int unsigned cut = 0);
    logic [63:0] len64;
    len64 = 64'(len);
    send_byte({fin, 3'($urandom_range(7)), op});
    case (form)
      FORM_7BIT: send_byte({masked, len64[6:0]});
      FORM_16BIT: begin
        send_byte({masked, 7'd126});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({masked, 7'd127});
        for (int i = 7; i >= 0; i--) send_byte(len64[i * 8 +: 8]);
      end
    endcase
    if (masked) repeat (4) send_byte(8'($urandom_range(255)));
    repeat (len - cut) send_byte(8'($urandom_range(255)));
  endtask

  task automatic send_random_frame();
    int unsigned sel;
    int unsigned len;
    len_form_t   form;
    finish_open_frame();
    sel = $urandom_range(99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 6)) send_noise_byte();
      return;
    end
    sel = $urandom_range(99);
    if (sel < 15) len = 0;
    else if (sel < 85) len = $urandom_range(1, 8);
    else if (sel < 95) len = $urandom_range(9, 40);
    else len = $urandom_range(126, 300);
    sel = $urandom_range(9);
    if (len > 125 || sel == 0) form = FORM_16BIT;
    else if (sel == 1) form = FORM_64BIT;
    else form = FORM_7BIT;
    send_frame(1'($urandom_range(99) < 60), pick_opcode(), len, 1'($urandom_range(1)), form,
               ($urandom_range(99) < 5 && len > 1) ? $urandom_range(1, len - 1) : 0);
  endtask

  task automatic send_random_bytes(input int unsigned count);
    int unsigned target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_frame();
  endtask

  // wait until every expected beat is out, then the output register latency
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_deliver_binary(input bit value);
    finish_open_frame();
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {wsd_pkg::REG_DELIVER_BINARY, 2'b00};
    cfg_pwdata  <= {31'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.deliver_binary      = value;
    tx_view.deliver_binary = value;
  endtask

  initial begin
    logic [3:0] bad_op;
    sb          = new();
    tx_view     = new();
    tx_idle_pct = 27;
    rx_idle_pct = 27;
    rx_hold_req = 0;
    stall_cycles = 0;
    bytes_sent  = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_deliver_binary(1'b0);
    send_frame(1, wsd_pkg::OP_TEXT, 0, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_TEXT, 5, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_BIN, 3, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_BIN, 0, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_PING, 4, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_PONG, 3, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_PONG, 0, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CLOSE, 0, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CLOSE, 1, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CLOSE, 6, 1, FORM_7BIT);
    // fragmented text with a ping between the pieces
    send_frame(0, wsd_pkg::OP_TEXT, 3, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_PING, 2, 0, FORM_7BIT);
    send_frame(0, wsd_pkg::OP_CONT, 2, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CONT, 2, 0, FORM_7BIT);
    // continuations with no message open
    send_frame(1, wsd_pkg::OP_CONT, 2, 1, FORM_7BIT);
    send_frame(0, wsd_pkg::OP_CONT, 0, 0, FORM_7BIT);
    // control frame with FIN clear still ends on its last byte
    send_frame(0, wsd_pkg::OP_PING, 3, 0, FORM_7BIT);
    // binary start replaces an open text message
    send_frame(0, wsd_pkg::OP_TEXT, 2, 0, FORM_7BIT);
    send_frame(0, wsd_pkg::OP_BIN, 2, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CONT, 2, 0, FORM_7BIT);
    send_frame(0, wsd_pkg::OP_TEXT, 0, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CONT, 0, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_TEXT, 130, 1, FORM_16BIT);
    send_frame(1, wsd_pkg::OP_TEXT, 7, 1, FORM_64BIT);
    send_frame(1, wsd_pkg::OP_PONG, 20, 0, FORM_16BIT);

    write_deliver_binary(1'b1);
    send_frame(0, wsd_pkg::OP_BIN, 3, 1, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_CONT, 2, 0, FORM_7BIT);
    send_frame(1, wsd_pkg::OP_BIN, 0, 0, FORM_7BIT);
    send_random_bytes(130);

    write_deliver_binary(1'b0);
    send_random_bytes(60);
    finish_open_frame();
    wait_idle();
    send_random_bytes(70);

    write_deliver_binary(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_bytes(90);
    tx_idle_pct = 27;
    rx_idle_pct = 27;
    finish_open_frame();
    rx_hold_req = 300;
    send_frame(1, wsd_pkg::OP_TEXT, 40, 1, FORM_7BIT);
    send_random_bytes(70);

    // a bad opcode stops the parser; what follows is ignored
    finish_open_frame();
    do bad_op = 4'($urandom_range(15)); while (frame_scoreboard::known_opcode(bad_op));
    send_byte({1'($urandom_range(1)), 3'($urandom_range(7)), bad_op});
    repeat (5) send_byte(8'($urandom_range(255)));
    wait_idle();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/wsd_pkg.sv
hdl/wsd_parser.sv
hdl/websocket_frame_deframer_core.sv
verif/tb.sv
